### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sha1_pkg.sv
// Shared types, constants and a helper function of the SHA-1 engine.
package sha1_pkg;

    localparam int unsigned NUM_H = 5;
    localparam int unsigned NUM_W = 16;

    localparam logic [31:0] H_INIT [NUM_H] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };

    localparam logic [31:0] MARK_WORD = 32'h8000_0000;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        PUSH_IN,
        PUSH_MARK,
        PUSH_ZERO,
        PUSH_LEN_HI,
        PUSH_LEN_LO
    } push_sel_t;

    typedef struct packed {
        logic      push;
        push_sel_t push_sel;
        logic [2:0] nb;
        logic      len_add;
        logic      init;
        logic      round;
        logic [1:0] grp;
        logic      fold;
        logic      finish;
    } dp_cmd_t;

    // Keep the valid leading bytes and, when fewer than four, append the 0x80 marker after them.
    function automatic logic [31:0] pad_word(input logic [31:0] word, input logic [2:0] nb);
        logic [31:0] res;
        unique case (nb)
            3'd0:    res = MARK_WORD;
            3'd1:    res = {word[31:24], 24'h80_0000};
            3'd2:    res = {word[31:16], 16'h8000};
            3'd3:    res = {word[31:8], 8'h80};
            default: res = word;
        endcase
        return res;
    endfunction

endpackage

### rtl/sha1_hash_engine_core.sv
// SHA-1 engine: message words in, a five-word digest out per message.
// Each message word is taken while the engine is idle. A full 16-word block then
// runs through one round unit, one round per cycle: the working registers are
// loaded, 80 rounds run and the result is added into the chaining value.
// After the last word the sequencer pushes the marker (unless the last word
// already holds it), zero padding and the 64-bit bit length one word per cycle,
// with one or two more compressions, and the digest is copied to the output
// registers in the done state once any earlier digest has been taken. The
// next message can start while the digest still waits to be taken.
module sha1_hash_engine_core
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_final_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word_0,
    output logic [31:0] m_digest_word_1,
    output logic [31:0] m_digest_word_2,
    output logic [31:0] m_digest_word_3,
    output logic [31:0] m_digest_word_4
);

    dp_cmd_t     cmd;
    logic [31:0] digest [NUM_H];

    sha1_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_valid_bytes (s_valid_bytes),
        .s_final_word  (s_final_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd)
    );

    sha1_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_message_word (s_message_word),
        .digest         (digest)
    );

    assign m_digest_word_0 = digest[0];
    assign m_digest_word_1 = digest[1];
    assign m_digest_word_2 = digest[2];
    assign m_digest_word_3 = digest[3];
    assign m_digest_word_4 = digest[4];

endmodule

### rtl/sha1_ctrl.sv
// Sequencer of the SHA-1 engine: word loading, padding, rounds and result handoff.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_valid_bytes,
    input  logic       s_final_word,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN_LO,
        S_INIT,
        S_ROUND,
        S_FOLD,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [3:0] fill_reg, fill_next;
    logic [6:0] round_reg, round_next;
    logic       mark_reg, mark_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] nb_sat;

    assign nb_sat  = (s_valid_bytes > FULL_BYTES) ? FULL_BYTES : s_valid_bytes;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        mark_next    = mark_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.push_sel = PUSH_ZERO;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_IN;
                    cmd.len_add  = 1'b1;
                    cmd.nb       = s_final_word ? nb_sat : FULL_BYTES;
                    fill_next    = fill_reg + 4'd1;
                    if (s_final_word) begin
                        mark_next = (nb_sat == FULL_BYTES);
                        ret_next  = S_PAD;
                        state_next = (fill_reg == 4'd15) ? S_INIT : S_PAD;
                    end else if (fill_reg == 4'd15) begin
                        ret_next   = S_IDLE;
                        state_next = S_INIT;
                    end
                end
            end
            S_PAD: begin
                cmd.push  = 1'b1;
                fill_next = fill_reg + 4'd1;
                if (mark_reg) begin
                    cmd.push_sel = PUSH_MARK;
                    mark_next    = 1'b0;
                    if (fill_reg == 4'd15) begin
                        ret_next   = S_PAD;
                        state_next = S_INIT;
                    end
                end else if (fill_reg == 4'd14) begin
                    cmd.push_sel = PUSH_LEN_HI;
                    state_next   = S_LEN_LO;
                end else begin
                    cmd.push_sel = PUSH_ZERO;
                    if (fill_reg == 4'd15) begin
                        ret_next   = S_PAD;
                        state_next = S_INIT;
                    end
                end
            end
            S_LEN_LO: begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_LEN_LO;
                fill_next    = fill_reg + 4'd1;
                ret_next     = S_DONE;
                state_next   = S_INIT;
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                if (round_reg < 7'd20) begin
                    cmd.grp = 2'd0;
                end else if (round_reg < 7'd40) begin
                    cmd.grp = 2'd1;
                end else if (round_reg < 7'd60) begin
                    cmd.grp = 2'd2;
                end else begin
                    cmd.grp = 2'd3;
                end
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            fill_reg    <= '0;
            round_reg   <= '0;
            mark_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            mark_reg    <= mark_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/sha1_dp.sv
// Datapath of the SHA-1 engine: schedule window, round registers, chaining value, length.
module sha1_dp
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic [31:0] s_message_word,
    output logic [31:0] digest [NUM_H]
);

    logic [31:0] w_reg  [NUM_W];
    logic [31:0] cv_reg [NUM_H];
    logic [31:0] dig_reg [NUM_H];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] len_reg;

    logic [31:0] push_word;
    logic [31:0] sched_x, sched_new;
    logic [31:0] f_val, t_val;

    always_comb begin
        case (cmd.push_sel)
            PUSH_IN:     push_word = pad_word(s_message_word, cmd.nb);
            PUSH_MARK:   push_word = MARK_WORD;
            PUSH_LEN_HI: push_word = len_reg[63:32];
            PUSH_LEN_LO: push_word = len_reg[31:0];
            default:     push_word = '0;
        endcase
    end

    assign sched_x   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched_new = {sched_x[30:0], sched_x[31]};

    always_comb begin
        case (cmd.grp)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + K_ROUND[cmd.grp] + w_reg[0];

    always_ff @(posedge aclk) begin
        if (cmd.push || cmd.round) begin
            for (int i = 0; i < NUM_W - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[NUM_W - 1] <= cmd.push ? push_word : sched_new;
        end
        if (cmd.init) begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end else if (cmd.round) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.finish) begin
            for (int i = 0; i < NUM_H; i++) begin
                dig_reg[i] <= cv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_H; i++) begin
                cv_reg[i] <= H_INIT[i];
            end
            len_reg <= '0;
        end else begin
            if (cmd.fold) begin
                cv_reg[0] <= cv_reg[0] + a_reg;
                cv_reg[1] <= cv_reg[1] + b_reg;
                cv_reg[2] <= cv_reg[2] + c_reg;
                cv_reg[3] <= cv_reg[3] + d_reg;
                cv_reg[4] <= cv_reg[4] + e_reg;
            end else if (cmd.finish) begin
                for (int i = 0; i < NUM_H; i++) begin
                    cv_reg[i] <= H_INIT[i];
                end
            end
            if (cmd.finish) begin
                len_reg <= '0;
            end else if (cmd.len_add) begin
                len_reg <= len_reg + {58'd0, cmd.nb, 3'd0};
            end
        end
    end

    assign digest = dig_reg;

endmodule

### rtl/sha1_checker.sv
// Port-level checks of the SHA-1 engine, bound to the top level.
`include "assert_macros.svh"

module sha1_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_final_word,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word_0,
    input logic [31:0] m_digest_word_1,
    input logic [31:0] m_digest_word_2,
    input logic [31:0] m_digest_word_3,
    input logic [31:0] m_digest_word_4
);

    logic s_beat;
    logic m_beat;
    logic [159:0] dig_all;

    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid && m_ready;
    assign dig_all = {m_digest_word_0, m_digest_word_1, m_digest_word_2,
                      m_digest_word_3, m_digest_word_4};

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(dig_all))
    // engine is busy (padding or compressing) right after a last beat
    `ASSERT_NEXT(a_busy_after_last, s_beat && s_final_word, !s_ready)
    // a digest is loaded only from the busy handoff cycle
    `ASSERT_SAME(a_load_when_busy, $rose(m_valid), $past(!s_ready))
    // no back-to-back digests while the engine is idle
    `ASSERT_NEXT(a_single_result, m_beat && s_ready, !m_valid)

endmodule

bind sha1_hash_engine_core sha1_checker u_chk (.*);
